// ----- src/bdd_pkg.sv -----
`default_nettype none

package bdd_pkg;

   // Field widths of one descriptor beat and one result beat.
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned BASE_W   = 48;
   localparam int unsigned STRIDE_W = 14;
   localparam int unsigned COUNT_W  = 32;
   localparam int unsigned FMT_W    = 4;
   localparam int unsigned COMP_W   = 3;
   localparam int unsigned SIZE_W   = 32;
   localparam int unsigned DFMT_W   = 7;
   localparam int unsigned PROD_W   = COUNT_W + STRIDE_W;

   // Bit positions within the descriptor words.
   localparam int unsigned STRIDE_LSB = 16;
   localparam int unsigned DFMT_LSB   = 12;

   // Data format codes.
   localparam logic [FMT_W-1:0] FMT_UNKNOWN = 4'd0;
   localparam logic [FMT_W-1:0] FMT_UNORM8  = 4'd1;
   localparam logic [FMT_W-1:0] FMT_SNORM8  = 4'd2;
   localparam logic [FMT_W-1:0] FMT_UINT8   = 4'd3;
   localparam logic [FMT_W-1:0] FMT_SINT8   = 4'd4;
   localparam logic [FMT_W-1:0] FMT_UNORM16 = 4'd5;
   localparam logic [FMT_W-1:0] FMT_SNORM16 = 4'd6;
   localparam logic [FMT_W-1:0] FMT_UINT16  = 4'd7;
   localparam logic [FMT_W-1:0] FMT_SINT16  = 4'd8;
   localparam logic [FMT_W-1:0] FMT_FLOAT16 = 4'd9;
   localparam logic [FMT_W-1:0] FMT_UINT32  = 4'd10;
   localparam logic [FMT_W-1:0] FMT_SINT32  = 4'd11;
   localparam logic [FMT_W-1:0] FMT_FLOAT32 = 4'd12;

   typedef struct packed {
      logic [FMT_W-1:0]  code;
      logic [COMP_W-1:0] comps;
   } fmt_entry_type;

   typedef struct packed {
      logic [BASE_W-1:0]   base_address;
      logic [STRIDE_W-1:0] stride;
      logic [COUNT_W-1:0]  record_count;
      logic [FMT_W-1:0]    format_code;
      logic [COMP_W-1:0]   component_count;
      logic [SIZE_W-1:0]   byte_size;
   } result_type;

   // Combined format lookup; unlisted values decode as unknown with no components.
   function automatic fmt_entry_type fmt_lookup(input logic [DFMT_W-1:0] dfmt);
      fmt_entry_type e;
      e = '{code: FMT_UNKNOWN, comps: 3'd0};
      unique case (dfmt)
         7'd1:    e = '{FMT_UNORM8,  3'd1};
         7'd2:    e = '{FMT_SNORM8,  3'd1};
         7'd5:    e = '{FMT_UINT8,   3'd1};
         7'd6:    e = '{FMT_SINT8,   3'd1};
         7'd7:    e = '{FMT_UNORM16, 3'd1};
         7'd8:    e = '{FMT_SNORM16, 3'd1};
         7'd11:   e = '{FMT_UINT16,  3'd1};
         7'd12:   e = '{FMT_SINT16,  3'd1};
         7'd13:   e = '{FMT_FLOAT16, 3'd1};
         7'd14:   e = '{FMT_UNORM8,  3'd2};
         7'd15:   e = '{FMT_SNORM8,  3'd2};
         7'd18:   e = '{FMT_UINT8,   3'd2};
         7'd19:   e = '{FMT_SINT8,   3'd2};
         7'd20:   e = '{FMT_UINT32,  3'd1};
         7'd21:   e = '{FMT_SINT32,  3'd1};
         7'd22:   e = '{FMT_FLOAT32, 3'd1};
         7'd23:   e = '{FMT_UNORM16, 3'd2};
         7'd24:   e = '{FMT_SNORM16, 3'd2};
         7'd27:   e = '{FMT_UINT16,  3'd2};
         7'd28:   e = '{FMT_SINT16,  3'd2};
         7'd29:   e = '{FMT_FLOAT16, 3'd2};
         7'd56:   e = '{FMT_UNORM8,  3'd4};
         7'd57:   e = '{FMT_SNORM8,  3'd4};
         7'd60:   e = '{FMT_UINT8,   3'd4};
         7'd61:   e = '{FMT_SINT8,   3'd4};
         7'd62:   e = '{FMT_UINT32,  3'd2};
         7'd63:   e = '{FMT_SINT32,  3'd2};
         7'd64:   e = '{FMT_FLOAT32, 3'd2};
         7'd65:   e = '{FMT_UNORM16, 3'd4};
         7'd66:   e = '{FMT_SNORM16, 3'd4};
         7'd69:   e = '{FMT_UINT16,  3'd4};
         7'd70:   e = '{FMT_SINT16,  3'd4};
         7'd71:   e = '{FMT_FLOAT16, 3'd4};
         7'd72:   e = '{FMT_UINT32,  3'd3};
         7'd73:   e = '{FMT_SINT32,  3'd3};
         7'd74:   e = '{FMT_FLOAT32, 3'd3};
         7'd75:   e = '{FMT_UINT32,  3'd4};
         7'd76:   e = '{FMT_SINT32,  3'd4};
         7'd77:   e = '{FMT_FLOAT32, 3'd4};
         default: e = '{FMT_UNKNOWN, 3'd0};
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

// ----- src/bdd_decode.sv -----
`default_nettype none

module bdd_decode (
   input  wire logic [bdd_pkg::WORD_W-1:0] word0,
   input  wire logic [bdd_pkg::WORD_W-1:0] word1,
   input  wire logic [bdd_pkg::WORD_W-1:0] word2,
   input  wire logic [bdd_pkg::WORD_W-1:0] word3,
   output bdd_pkg::result_type             result
);
   import bdd_pkg::*;

   logic [STRIDE_W-1:0] stride;
   logic [PROD_W-1:0]   product;
   fmt_entry_type       fmt;

   // Field extraction straight from the descriptor words.
   assign stride  = word1[STRIDE_LSB +: STRIDE_W];
   assign fmt     = fmt_lookup(word3[DFMT_LSB +: DFMT_W]);
   assign product = PROD_W'(word2) * PROD_W'(stride);

   // Byte size: raw count when unstrided, otherwise the product saturated to 32 bits.
   always_comb begin
      result.base_address    = {word1[BASE_W-WORD_W-1:0], word0};
      result.stride          = stride;
      result.record_count    = word2;
      result.format_code     = fmt.code;
      result.component_count = fmt.comps;
      if (stride == '0) begin
         result.byte_size = word2;
      end else if (product[PROD_W-1:SIZE_W] != '0) begin
         result.byte_size = '1;
      end else begin
         result.byte_size = product[SIZE_W-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- src/buffer_descriptor_decoder_top.sv -----
`default_nettype none

// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_ready   word0, word1, word2, word3
// rsp_      out        rsp_valid / rsp_ready   base_address, stride, record_count,
//                                              format_code, component_count, byte_size
//
// One descriptor beat is accepted per cycle while the input register is empty or the
// result register is free; a beat passes the input register, then the result register.
// The path between the input register and the result register holds the
// 32 x 14 record-count multiply, the saturation compare and the format table.
// Reset is synchronous and clears only the two valid flags.
// A stalled result holds the result register; the input register still takes a
// beat while it is empty, so one beat is buffered while the output waits.

module buffer_descriptor_decoder_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [bdd_pkg::WORD_W-1:0]     req_word0,
   input  wire logic [bdd_pkg::WORD_W-1:0]     req_word1,
   input  wire logic [bdd_pkg::WORD_W-1:0]     req_word2,
   input  wire logic [bdd_pkg::WORD_W-1:0]     req_word3,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [bdd_pkg::BASE_W-1:0]          rsp_base_address,
   output logic [bdd_pkg::STRIDE_W-1:0]        rsp_stride,
   output logic [bdd_pkg::COUNT_W-1:0]         rsp_record_count,
   output logic [bdd_pkg::FMT_W-1:0]           rsp_format_code,
   output logic [bdd_pkg::COMP_W-1:0]          rsp_component_count,
   output logic [bdd_pkg::SIZE_W-1:0]          rsp_byte_size
);
   import bdd_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [WORD_W-1:0] word0_ff, word1_ff, word2_ff, word3_ff;
   logic              out_valid_ff, out_valid_in;
   result_type        result_ff;
   result_type        decoded;
   logic              out_free;
   logic              advance;

   // Handshake control: the result register frees when empty or being taken.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !out_free);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register loads on every accepted beat.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         word0_ff <= req_word0;
         word1_ff <= req_word1;
         word2_ff <= req_word2;
         word3_ff <= req_word3;
      end
   end

   bdd_decode u_decode (
      .word0  (word0_ff),
      .word1  (word1_ff),
      .word2  (word2_ff),
      .word3  (word3_ff),
      .result (decoded)
   );

   // Result register loads when the decoded beat moves forward.
   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= decoded;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_base_address    = result_ff.base_address;
   assign rsp_stride          = result_ff.stride;
   assign rsp_record_count    = result_ff.record_count;
   assign rsp_format_code     = result_ff.format_code;
   assign rsp_component_count = result_ff.component_count;
   assign rsp_byte_size       = result_ff.byte_size;

   // A beat held in the input register is not lost while the output stalls.
   a_hold_in: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> (in_valid_ff && $stable(word2_ff)))
      else $error("input register lost a beat during an output stall");

   // A beat that moves forward shows up as the next result with its record count.
   a_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_valid_ff && rsp_record_count == $past(word2_ff)))
      else $error("advanced beat did not reach the result register");

   // An unknown format always comes with no components, and only then.
   a_fmt_comps: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((rsp_format_code == FMT_UNKNOWN) == (rsp_component_count == '0)))
      else $error("format code and component count disagree");

   // An unstrided result reports the raw record count as its size.
   a_unstrided: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stride == '0) |-> (rsp_byte_size == rsp_record_count))
      else $error("unstrided size differs from record count");

   // Reset empties both registers.
   a_reset: assert property (@(posedge clock)
      reset |=> (!in_valid_ff && !out_valid_ff))
      else $error("valid flags not cleared by reset");

endmodule

`default_nettype wire

// ----- tb/sv/buffer_descriptor_decoder_top_tb.sv -----
`timescale 1ns / 1ps

module buffer_descriptor_decoder_top_tb;

   import bdd_pkg::*;

   typedef struct packed {
      logic [WORD_W-1:0] w0;
      logic [WORD_W-1:0] w1;
      logic [WORD_W-1:0] w2;
      logic [WORD_W-1:0] w3;
   } descriptor_type;

   localparam int unsigned RANDOM_DESCRIPTORS = 1930;
   localparam int unsigned STALL_CYCLES       = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [WORD_W-1:0] req_word0 = '0;
   logic [WORD_W-1:0] req_word1 = '0;
   logic [WORD_W-1:0] req_word2 = '0;
   logic [WORD_W-1:0] req_word3 = '0;

   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [BASE_W-1:0]   rsp_base_address;
   logic [STRIDE_W-1:0] rsp_stride;
   logic [COUNT_W-1:0]  rsp_record_count;
   logic [FMT_W-1:0]    rsp_format_code;
   logic [COMP_W-1:0]   rsp_component_count;
   logic [SIZE_W-1:0]   rsp_byte_size;

   descriptor_type descriptor_q[$];
   result_type     decoded_q[$];

   int unsigned descriptor_total   = 0;
   int unsigned descriptors_taken  = 0;
   int unsigned results_checked    = 0;
   int unsigned mismatch_count     = 0;
   int unsigned idle_phase         = 0;
   int unsigned stall_left         = 0;
   bit          stall_done         = 1'b0;
   bit          req_taken          = 1'b0;

   buffer_descriptor_decoder_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_word0           (req_word0),
      .req_word1           (req_word1),
      .req_word2           (req_word2),
      .req_word3           (req_word3),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_base_address    (rsp_base_address),
      .rsp_stride          (rsp_stride),
      .rsp_record_count    (rsp_record_count),
      .rsp_format_code     (rsp_format_code),
      .rsp_component_count (rsp_component_count),
      .rsp_byte_size       (rsp_byte_size)
   );

   always #5 clock = ~clock;

   // Data format named by a combined format value; unlisted values are unknown.
   function automatic logic [FMT_W-1:0] format_code_of(input logic [DFMT_W-1:0] dfmt);
      case (dfmt)
         7'd1, 7'd14, 7'd56:          return FMT_UNORM8;
         7'd2, 7'd15, 7'd57:          return FMT_SNORM8;
         7'd5, 7'd18, 7'd60:          return FMT_UINT8;
         7'd6, 7'd19, 7'd61:          return FMT_SINT8;
         7'd7, 7'd23, 7'd65:          return FMT_UNORM16;
         7'd8, 7'd24, 7'd66:          return FMT_SNORM16;
         7'd11, 7'd27, 7'd69:         return FMT_UINT16;
         7'd12, 7'd28, 7'd70:         return FMT_SINT16;
         7'd13, 7'd29, 7'd71:         return FMT_FLOAT16;
         7'd20, 7'd62, 7'd72, 7'd75:  return FMT_UINT32;
         7'd21, 7'd63, 7'd73, 7'd76:  return FMT_SINT32;
         7'd22, 7'd64, 7'd74, 7'd77:  return FMT_FLOAT32;
         default:                     return FMT_UNKNOWN;
      endcase
   endfunction

   // Components per element for a combined format value.
   function automatic logic [COMP_W-1:0] component_count_of(input logic [DFMT_W-1:0] dfmt);
      case (dfmt)
         7'd1, 7'd2, 7'd5, 7'd6, 7'd7, 7'd8, 7'd11, 7'd12, 7'd13,
         7'd20, 7'd21, 7'd22:
            return 3'd1;
         7'd14, 7'd15, 7'd18, 7'd19, 7'd23, 7'd24, 7'd27, 7'd28, 7'd29,
         7'd62, 7'd63, 7'd64:
            return 3'd2;
         7'd72, 7'd73, 7'd74:
            return 3'd3;
         7'd56, 7'd57, 7'd60, 7'd61, 7'd65, 7'd66, 7'd69, 7'd70, 7'd71,
         7'd75, 7'd76, 7'd77:
            return 3'd4;
         default:
            return 3'd0;
      endcase
   endfunction

   // Decoded view of one descriptor, as the block should present it.
   function automatic result_type decode_descriptor(input descriptor_type d);
      result_type         r;
      logic [DFMT_W-1:0]  dfmt;
      logic [PROD_W-1:0]  product;
      r.base_address    = {d.w1[15:0], d.w0};
      r.stride          = d.w1[STRIDE_LSB +: STRIDE_W];
      r.record_count    = d.w2;
      dfmt              = d.w3[DFMT_LSB +: DFMT_W];
      r.format_code     = format_code_of(dfmt);
      r.component_count = component_count_of(dfmt);
      product           = PROD_W'(d.w2) * PROD_W'(r.stride);
      if (r.stride == '0)
         r.byte_size = d.w2;
      else if (product > PROD_W'(32'hFFFF_FFFF))
         r.byte_size = '1;
      else
         r.byte_size = product[SIZE_W-1:0];
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] expected,
                                       input logic [63:0] actual);
      if (actual !== expected) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, expected, actual);
         mismatch_count++;
      end
   endfunction

   function automatic descriptor_type make_descriptor(input logic [31:0] w0,
         input logic [15:0] base_hi, input logic [STRIDE_W-1:0] stride,
         input logic [31:0] count, input logic [DFMT_W-1:0] dfmt);
      descriptor_type d;
      d.w0 = w0;
      d.w1 = {2'b00, stride, base_hi};
      d.w2 = count;
      d.w3 = '0;
      d.w3[DFMT_LSB +: DFMT_W] = dfmt;
      return d;
   endfunction

   // Appends one descriptor to the tail of the pending queue.
   function automatic void add_descriptor(input descriptor_type d);
      descriptor_q.insert(descriptor_q.size(), d);
   endfunction

   // Stimulus: directed corners first, then random descriptors, then the drain.
   initial begin : stimulus
      descriptor_type    d;
      logic [STRIDE_W-1:0] stride;
      logic [31:0]       count;
      logic [DFMT_W-1:0] dfmt;

      d = '0;
      add_descriptor(d);
      d = '1;
      add_descriptor(d);
      add_descriptor(make_descriptor(32'hFFFF_FFFF, 16'hFFFF, 14'd0,
                                     32'hFFFF_FFFF, 7'd1));
      add_descriptor(make_descriptor(32'h0, 16'h0, 14'd1, 32'hFFFF_FFFF, 7'd77));
      add_descriptor(make_descriptor(32'h1234_5678, 16'h9ABC, 14'd2,
                                     32'h8000_0000, 7'd72));
      add_descriptor(make_descriptor(32'h8000_0000, 16'h8000, 14'd2,
                                     32'h7FFF_FFFF, 7'd56));
      add_descriptor(make_descriptor(32'h0, 16'h0, 14'h3FFF, 32'd0, 7'd22));
      add_descriptor(make_descriptor(32'h0, 16'h0, 14'h3FFF, 32'd1, 7'd13));
      add_descriptor(make_descriptor(32'h0, 16'h0, 14'h3FFF,
                                     32'hFFFF_FFFF / 32'h3FFF, 7'd64));
      add_descriptor(make_descriptor(32'h0, 16'h0, 14'h3FFF,
                                     32'hFFFF_FFFF / 32'h3FFF + 32'd1, 7'd75));
      add_descriptor(make_descriptor(32'hDEAD_BEEF, 16'h0001, 14'd0, 32'd0, 7'd3));
      add_descriptor(make_descriptor(32'h1, 16'h0, 14'd16, 32'd64, 7'd78));
      add_descriptor(make_descriptor(32'h1, 16'h0, 14'd4, 32'd100, 7'd127));
      add_descriptor(make_descriptor(32'h1, 16'h0, 14'd12, 32'd3, 7'd29));
      add_descriptor(make_descriptor(32'h1, 16'h0, 14'd8, 32'd5, 7'd55));
      // Ignored bits: stride's upper neighbours and word 3 outside the format field.
      d = make_descriptor(32'hA5A5_A5A5, 16'h5A5A, 14'd6, 32'd1000, 7'd20);
      d.w1[31:30] = 2'b11;
      d.w3 = d.w3 | 32'hFFF8_0FFF;
      add_descriptor(d);
      d = make_descriptor(32'h0, 16'h0, 14'd0, 32'd7, 7'd0);
      d.w1[31:30] = 2'b10;
      d.w3 = 32'hFFF8_0FFF;
      add_descriptor(d);

      // Random descriptors with the stride, count and format biased to edges.
      repeat (RANDOM_DESCRIPTORS) begin
         case ($urandom_range(5))
            0:       stride = '0;
            1:       stride = 14'h3FFF;
            2:       stride = STRIDE_W'($urandom_range(1, 16));
            default: stride = STRIDE_W'($urandom_range(16383));
         endcase
         case ($urandom_range(5))
            0:       count = $urandom_range(255);
            1:       count = 32'hFFFF_FFFF;
            2:       count = (stride != '0) ? 32'hFFFF_FFFF / stride + $urandom_range(1)
                                            : $urandom();
            default: count = $urandom();
         endcase
         if ($urandom_range(3) != 0) begin
            do dfmt = DFMT_W'($urandom_range(127));
            while (format_code_of(dfmt) == FMT_UNKNOWN);
         end else begin
            dfmt = DFMT_W'($urandom_range(127));
         end
         d.w0 = $urandom();
         d.w1 = $urandom();
         d.w1[STRIDE_LSB +: STRIDE_W] = stride;
         d.w2 = count;
         d.w3 = $urandom();
         d.w3[DFMT_LSB +: DFMT_W] = dfmt;
         add_descriptor(d);
      end
      descriptor_total = descriptor_q.size();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (descriptors_taken == descriptor_total);
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && decoded_q.size() == 0 &&
          results_checked == descriptor_total)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Idle rates move through three phases as descriptors are taken.
   always @(negedge clock) begin
      if (descriptor_total == 0 || descriptors_taken < descriptor_total / 3)
         idle_phase <= 0;
      else if (descriptors_taken < 2 * descriptor_total / 3)
         idle_phase <= 1;
      else
         idle_phase <= 2;
   end

   // Driver: offers the next descriptor once the current beat has gone.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (descriptor_q.size() != 0 &&
             $urandom_range(99) >= (idle_phase == 0 ? 6 : idle_phase == 1 ? 51 : 0)) begin
            req_valid <= 1'b1;
            req_word0 <= descriptor_q[0].w0;
            req_word1 <= descriptor_q[0].w1;
            req_word2 <= descriptor_q[0].w2;
            req_word3 <= descriptor_q[0].w3;
            void'(descriptor_q.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure, plus one long hold-off with no idling around it.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!stall_done && idle_phase == 2) begin
         stall_done <= 1'b1;
         stall_left <= STALL_CYCLES;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= (idle_phase == 0 ? 51 : idle_phase == 1 ? 6 : 0));
      end
   end

   // Monitor: checks each result beat, then records each accepted descriptor.
   always @(posedge clock) begin
      result_type expected;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (decoded_q.size() == 0) begin
               $error("result beat with no descriptor outstanding");
               mismatch_count++;
            end else begin
               expected = decoded_q.pop_front();
               check_field("base_address", 64'(expected.base_address), 64'(rsp_base_address));
               check_field("stride", 64'(expected.stride), 64'(rsp_stride));
               check_field("record_count", 64'(expected.record_count), 64'(rsp_record_count));
               check_field("format_code", 64'(expected.format_code), 64'(rsp_format_code));
               check_field("component_count", 64'(expected.component_count),
                           64'(rsp_component_count));
               check_field("byte_size", 64'(expected.byte_size), 64'(rsp_byte_size));
            end
            results_checked++;
         end
         if (req_valid && req_ready) begin
            decoded_q.insert(decoded_q.size(),
                             decode_descriptor({req_word0, req_word1, req_word2, req_word3}));
            descriptors_taken++;
         end
      end
   end

   // Watchdog for a hung handshake.
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
